// ----- rtl/mgac_pkg.sv -----
`default_nettype none

package mgac_pkg;

  // field widths
  localparam int unsigned CODE_W   = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ROW_W    = 7;
  localparam int unsigned IDX_W    = 15;
  localparam int unsigned OFF_W    = 26;
  localparam int unsigned INFO_W   = 32;
  localparam int unsigned HEIGHT_W = 6;
  localparam int unsigned HDR_W    = 16;
  localparam int unsigned CP_W     = 2;
  localparam int unsigned REG_IDX_W  = 2;
  localparam int unsigned REG_DATA_W = 16;

  // code page select codes
  localparam logic [CP_W-1:0] CP_932 = 2'd0;
  localparam logic [CP_W-1:0] CP_936 = 2'd1;
  localparam logic [CP_W-1:0] CP_949 = 2'd2;
  localparam logic [CP_W-1:0] CP_950 = 2'd3;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_CODEPAGE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HEADER   = 2'd2;

  // register reset values
  localparam logic [CP_W-1:0]     CODEPAGE_RST = CP_936;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST   = 6'd16;
  localparam logic [HDR_W-1:0]    HEADER_RST   = 16'd0;

  // cells per lead byte
  localparam logic [BYTE_W-1:0] CELLS_932 = 8'd188;
  localparam logic [BYTE_W-1:0] CELLS_936 = 8'd94;
  localparam logic [BYTE_W-1:0] CELLS_949 = 8'd188;
  localparam logic [BYTE_W-1:0] CELLS_950 = 8'd157;

  // largest glyph index over all code pages
  localparam logic [IDX_W-1:0] IDX_MAX = 15'd23875;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] idx;
  } decode_t;

endpackage

`default_nettype wire

// ----- rtl/mgac_if.sv -----
`default_nettype none

interface mgac_code_if import mgac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface mgac_result_if import mgac_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                code_valid;
  logic [IDX_W-1:0]    glyph_index;
  logic [OFF_W-1:0]    byte_offset;
  logic [INFO_W-1:0]   char_info;
  logic [HEIGHT_W-1:0] glyph_width;

  modport source (output valid, output code_valid, output glyph_index, output byte_offset,
                  output char_info, output glyph_width, input ready);
  modport sink   (input valid, input code_valid, input glyph_index, input byte_offset,
                  input char_info, input glyph_width, output ready);
endinterface

interface mgac_cfg_if import mgac_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  reg_index;
  logic [REG_DATA_W-1:0] reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

`default_nettype wire

// ----- rtl/mbcs_glyph_address_calc.sv -----
`default_nettype none

// double-byte character code to fixed-width glyph address. every code
// transfer on the code channel yields exactly one result transfer, in order.
// the lead byte (bits 15..8) and trail byte are range checked under the
// selected code page (932, 936, 949 or 950) and folded into a linear glyph
// index; the byte offset is header_bytes + index * ceil(h/PIXELS_PER_BYTE_N)
// * h, kept to 26 bits. out-of-range codes give an all-zero result. the
// block takes one code per cycle while the result side is ready; a result
// passes decode, index multiply and offset add, which each own one
// register stage. a stall on the result side holds the pipeline without
// dropping or repeating anything, and bubbles are squeezed out. registers
// (0 code page, 1 height, 2 header bytes) are written through the cfg
// channel, which is always ready; writes are expected only while the
// pipeline is empty, and a write to index 3 is ignored.
module mbcs_glyph_address_calc import mgac_pkg::*; #(
  parameter int unsigned PIXELS_PER_BYTE_N = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  mgac_cfg_if.sink            cfg,
  mgac_code_if.sink           code,
  mgac_result_if.source       result
);

  // bytes per glyph never exceeds ceil(63/N) * 63
  localparam int unsigned HEIGHT_MAX = (1 << HEIGHT_W) - 1;
  localparam int unsigned GB_MAX     =
    ((HEIGHT_MAX + PIXELS_PER_BYTE_N - 1) / PIXELS_PER_BYTE_N) * HEIGHT_MAX;
  localparam int unsigned GB_W       = $clog2(GB_MAX + 1);
  localparam int unsigned GB_DEPTH   = 1 << HEIGHT_W;

  // configuration registers
  logic [CP_W-1:0]     codepage_select;
  logic [HEIGHT_W-1:0] glyph_height;
  logic [HDR_W-1:0]    header_bytes;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      codepage_select <= CODEPAGE_RST;
      glyph_height    <= HEIGHT_RST;
      header_bytes    <= HEADER_RST;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        REG_CODEPAGE: codepage_select <= cfg.reg_data[CP_W-1:0];
        REG_HEIGHT:   glyph_height    <= cfg.reg_data[HEIGHT_W-1:0];
        REG_HEADER:   header_bytes    <= cfg.reg_data[HDR_W-1:0];
        default:      ;
      endcase
    end
  end

  // bytes per glyph for every height, worked out at elaboration
  logic [GB_W-1:0] glyph_tab [GB_DEPTH];

  for (genvar g = 0; g < GB_DEPTH; g++) begin : g_glyph_tab
    assign glyph_tab[g] =
      GB_W'(((g + PIXELS_PER_BYTE_N - 1) / PIXELS_PER_BYTE_N) * g);
  end

  // pipeline flow control: a stage takes new data when it is empty or
  // its contents move on in the same cycle
  logic s1_valid;
  logic s2_valid;
  logic s3_valid;
  logic s1_ready;
  logic s2_ready;
  logic s3_ready;

  assign s3_ready   = !s3_valid || result.ready;
  assign s2_ready   = !s2_valid || s3_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign code.ready = s1_ready;

  // stage 1: range check and linear index
  decode_t         dec;
  decode_t         s1_dec;
  logic [GB_W-1:0] s1_gb;

  mgac_decode u_decode (
    .char_code (code.char_code),
    .codepage  (codepage_select),
    .dec       (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= code.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_dec <= dec;
      s1_gb  <= glyph_tab[glyph_height];
    end
  end

  // stage 2: index times bytes per glyph, wraps at 26 bits
  decode_t          s2_dec;
  logic [OFF_W-1:0] s2_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_dec  <= s1_dec;
      s2_prod <= OFF_W'(s1_dec.idx * s1_gb);
    end
  end

  // stage 3: add header, pack result; invalid codes give all zeros
  logic [OFF_W-1:0]    offset_next;
  logic                s3_ok;
  logic [IDX_W-1:0]    s3_idx;
  logic [OFF_W-1:0]    s3_off;
  logic [HEIGHT_W-1:0] s3_height;

  assign offset_next = OFF_W'(s2_prod + OFF_W'(header_bytes));

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_ok     <= s2_dec.ok;
      s3_idx    <= s2_dec.idx;
      s3_off    <= s2_dec.ok ? offset_next : '0;
      s3_height <= s2_dec.ok ? glyph_height : '0;
    end
  end

  assign result.valid       = s3_valid;
  assign result.code_valid  = s3_ok;
  assign result.glyph_index = s3_idx;
  assign result.byte_offset = s3_off;
  assign result.char_info   = {s3_height, s3_off};
  assign result.glyph_width = s3_height;

  // invalid codes leave every field at zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.code_valid |->
      result.glyph_index == '0 && result.byte_offset == '0 &&
      result.char_info == '0 && result.glyph_width == '0)
    else $error("invalid code with nonzero result");

  // index never leaves the largest code page's range
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.glyph_index <= IDX_MAX)
    else $error("glyph index out of range");

  // an accepted code always lands in stage 1
  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    code.valid && code.ready |=> s1_valid)
    else $error("accepted code lost at stage 1");

  // a stalled result keeps the item behind it in stage 2
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    s3_valid && !result.ready && s2_valid |=> s2_valid && $stable(s2_prod))
    else $error("stage 2 changed under a stall");

endmodule

`default_nettype wire

// ----- rtl/mgac_decode.sv -----
`default_nettype none

module mgac_decode import mgac_pkg::*; (
  input  wire logic [CODE_W-1:0] char_code,
  input  wire logic [CP_W-1:0]   codepage,
  output decode_t                dec
);

  logic [BYTE_W-1:0] lead;
  logic [BYTE_W-1:0] trail;
  logic [ROW_W-1:0]  row;
  logic [BYTE_W-1:0] col;
  logic [BYTE_W-1:0] cells;
  logic              lead_ok;
  logic              trail_ok;

  assign lead  = char_code[CODE_W-1:BYTE_W];
  assign trail = char_code[BYTE_W-1:0];

  always_comb begin
    row      = '0;
    col      = '0;
    cells    = CELLS_936;
    lead_ok  = 1'b0;
    trail_ok = 1'b0;
    case (codepage)
      CP_932: begin
        cells = CELLS_932;
        // second lead block continues right after the first
        if (lead >= 8'h81 && lead <= 8'h9F) begin
          lead_ok = 1'b1;
          row     = ROW_W'(lead - 8'h81);
        end else if (lead >= 8'hE0 && lead <= 8'hFC) begin
          lead_ok = 1'b1;
          row     = ROW_W'(lead - 8'hC1);
        end
        if (trail >= 8'h40 && trail <= 8'h7E) begin
          trail_ok = 1'b1;
          col      = BYTE_W'(trail - 8'h40);
        end else if (trail >= 8'h80 && trail <= 8'hFC) begin
          trail_ok = 1'b1;
          col      = BYTE_W'(trail - 8'h41);
        end
      end
      CP_936: begin
        cells    = CELLS_936;
        lead_ok  = lead >= 8'hA1 && lead <= 8'hFE;
        trail_ok = trail >= 8'hA1 && trail <= 8'hFE;
        row      = ROW_W'(lead - 8'hA1);
        col      = BYTE_W'(trail - 8'hA1);
      end
      CP_949: begin
        cells   = CELLS_949;
        lead_ok = lead >= 8'h81;
        row     = ROW_W'(lead - 8'h81);
        if (trail >= 8'h41 && trail <= 8'h7E) begin
          trail_ok = 1'b1;
          col      = BYTE_W'(trail - 8'h41);
        end else if (trail >= 8'h81 && trail <= 8'hFE) begin
          trail_ok = 1'b1;
          col      = BYTE_W'(trail - 8'h43);
        end
      end
      CP_950: begin
        cells   = CELLS_950;
        lead_ok = lead >= 8'hA1 && lead <= 8'hFE;
        row     = ROW_W'(lead - 8'hA1);
        if (trail >= 8'h40 && trail <= 8'h7E) begin
          trail_ok = 1'b1;
          col      = BYTE_W'(trail - 8'h40);
        end else if (trail >= 8'hA1 && trail <= 8'hFE) begin
          trail_ok = 1'b1;
          col      = BYTE_W'(trail - 8'h62);
        end
      end
      default: begin
        lead_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    dec.ok  = lead_ok && trail_ok;
    dec.idx = '0;
    if (lead_ok && trail_ok) begin
      dec.idx = IDX_W'(IDX_W'(row) * IDX_W'(cells) + IDX_W'(col));
    end
  end

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import mgac_pkg::*;

  // block under test runs at its default of 8 pixels per byte
  localparam int unsigned PIX_PER_BYTE = 8;
  // decode, index multiply and offset add, one register each
  localparam int unsigned PIPE_DEPTH = 3;
  // register index 3 has no register behind it
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int unsigned N_DIR = 24;
  localparam int unsigned N_PHASES = 8;
  localparam int unsigned CODES_PER_PHASE = 203;
  // watchdog limit, with plenty of slack over the slowest pass
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned MAX_PRINTS = 100;

  typedef struct packed {
    logic                code_valid;
    logic [IDX_W-1:0]    glyph_index;
    logic [OFF_W-1:0]    byte_offset;
    logic [INFO_W-1:0]   char_info;
    logic [HEIGHT_W-1:0] glyph_width;
  } glyph_addr_t;

  typedef struct packed {
    logic [CODE_W-1:0] char_code;
    glyph_addr_t       addr;
  } pending_glyph_t;

  // one directed row: font setup, the code, and a typed-in result when lit is set
  typedef struct packed {
    logic [CP_W-1:0]     cp;
    logic [HEIGHT_W-1:0] height;
    logic [HDR_W-1:0]    header;
    logic [CODE_W-1:0]   char_code;
    logic                lit;
    glyph_addr_t         addr;
  } glyph_row_t;

  localparam glyph_addr_t NO_GLYPH = '0;

  localparam glyph_row_t GLYPH_ROWS [N_DIR] = '{
    // reset setup: gbk, height 16, no header; first cell sits at offset 0
    '{CP_936, 6'd16, 16'h0000, 16'hA1A1, 1'b1,
      '{1'b1, 15'd0, 26'd0, 32'h4000_0000, 6'd16}},
    '{CP_936, 6'd16, 16'h0000, 16'hFEFE, 1'b0, NO_GLYPH},
    '{CP_936, 6'd16, 16'h0000, 16'hA0A1, 1'b1, NO_GLYPH},
    '{CP_936, 6'd16, 16'h0000, 16'hA1FF, 1'b1, NO_GLYPH},
    '{CP_936, 6'd16, 16'h0000, 16'h0000, 1'b1, NO_GLYPH},
    '{CP_936, 6'd16, 16'h0000, 16'hFFFF, 1'b1, NO_GLYPH},
    // shift-jis, one pixel high, largest header
    '{CP_932, 6'd1, 16'hFFFF, 16'h8140, 1'b1,
      '{1'b1, 15'd0, 26'd65535, 32'h0400_FFFF, 6'd1}},
    '{CP_932, 6'd1, 16'hFFFF, 16'h817F, 1'b1, NO_GLYPH},
    '{CP_932, 6'd1, 16'hFFFF, 16'h9FFC, 1'b0, NO_GLYPH},
    '{CP_932, 6'd1, 16'hFFFF, 16'hE080, 1'b0, NO_GLYPH},
    '{CP_932, 6'd1, 16'hFFFF, 16'hFCFC, 1'b0, NO_GLYPH},
    '{CP_932, 6'd1, 16'hFFFF, 16'hA040, 1'b1, NO_GLYPH},
    '{CP_932, 6'd1, 16'hFFFF, 16'hFD40, 1'b1, NO_GLYPH},
    // korean, tallest glyph; FFFE gives the largest index of all pages
    '{CP_949, 6'd63, 16'hFFFF, 16'h8141, 1'b0, NO_GLYPH},
    '{CP_949, 6'd63, 16'hFFFF, 16'hFFFE, 1'b0, NO_GLYPH},
    '{CP_949, 6'd63, 16'hFFFF, 16'h81FF, 1'b1, NO_GLYPH},
    '{CP_949, 6'd63, 16'hFFFF, 16'h8180, 1'b1, NO_GLYPH},
    '{CP_949, 6'd63, 16'hFFFF, 16'h8041, 1'b1, NO_GLYPH},
    // big5 with zero height: offset is just the header, no height bits
    '{CP_950, 6'd0, 16'h1234, 16'hA140, 1'b1,
      '{1'b1, 15'd0, 26'h1234, 32'h0000_1234, 6'd0}},
    '{CP_950, 6'd0, 16'h1234, 16'hFEFE, 1'b0, NO_GLYPH},
    '{CP_950, 6'd0, 16'h1234, 16'hA17F, 1'b1, NO_GLYPH},
    '{CP_950, 6'd0, 16'h1234, 16'hA1A0, 1'b1, NO_GLYPH},
    '{CP_950, 6'd0, 16'h1234, 16'hA17E, 1'b0, NO_GLYPH},
    '{CP_950, 6'd0, 16'h1234, 16'h9F40, 1'b1, NO_GLYPH}
  };

  // bytes right at or next to some code page range limit
  localparam logic [BYTE_W-1:0] BOUNDARY_BYTES [16] = '{
    8'h3F, 8'h40, 8'h41, 8'h7E, 8'h7F, 8'h80, 8'h81, 8'h9F,
    8'hA0, 8'hA1, 8'hDF, 8'hE0, 8'hFC, 8'hFD, 8'hFE, 8'hFF
  };

  logic clk;
  logic rst;

  mgac_cfg_if    cfg_ch ();
  mgac_code_if   code_ch ();
  mgac_result_if result_ch ();

  mbcs_glyph_address_calc #(
    .PIXELS_PER_BYTE_N(PIX_PER_BYTE)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_ch),
    .code  (code_ch),
    .result(result_ch)
  );

  // font setup as the block should currently hold it
  logic [CP_W-1:0]     cp_sel    = CODEPAGE_RST;
  logic [HEIGHT_W-1:0] height_r  = HEIGHT_RST;
  logic [HDR_W-1:0]    header_r  = HEADER_RST;

  pending_glyph_t glyph_q [$];
  int unsigned    err_cnt   = 0;
  int unsigned    cycle_cnt = 0;
  // random gaps on both sides are allowed while this is set
  bit             idle_on   = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // glyph address for one code under the current font setup
  function automatic glyph_addr_t glyph_addr_of(logic [CODE_W-1:0] c);
    int unsigned lead;
    int unsigned trail;
    int unsigned base;
    int unsigned idx;
    int unsigned row_bytes;
    longint unsigned off;
    bit ok;
    glyph_addr_t r;
    r     = '0;
    lead  = c[15:8];
    trail = c[7:0];
    idx   = 0;
    base  = 0;
    ok    = 1'b0;
    case (cp_sel)
      CP_932: begin
        // two lead blocks, the upper one continues at 5828
        if (lead >= 'h81 && lead <= 'h9F) begin
          base = (lead - 'h81) * 188;
          ok = 1'b1;
        end else if (lead >= 'hE0 && lead <= 'hFC) begin
          base = 5828 + (lead - 'hE0) * 188;
          ok = 1'b1;
        end
        if (ok && trail >= 'h40 && trail <= 'h7E) begin
          idx = base + trail - 'h40;
        end else if (ok && trail >= 'h80 && trail <= 'hFC) begin
          idx = base + trail - 'h80 + 63;
        end else begin
          ok = 1'b0;
        end
      end
      CP_936: begin
        ok = lead >= 'hA1 && lead <= 'hFE && trail >= 'hA1 && trail <= 'hFE;
        idx = (lead - 'hA1) * 94 + trail - 'hA1;
      end
      CP_949: begin
        base = (lead - 'h81) * 188;
        if (lead >= 'h81 && trail >= 'h41 && trail <= 'h7E) begin
          idx = base + trail - 'h41;
          ok = 1'b1;
        end else if (lead >= 'h81 && trail >= 'h81 && trail <= 'hFE) begin
          idx = base + trail - 'h81 + 62;
          ok = 1'b1;
        end
      end
      default: begin
        base = (lead - 'hA1) * 157;
        if (lead >= 'hA1 && lead <= 'hFE) begin
          if (trail >= 'h40 && trail <= 'h7E) begin
            idx = base + trail - 'h40;
            ok = 1'b1;
          end else if (trail >= 'hA1 && trail <= 'hFE) begin
            idx = base + trail - 'hA1 + 63;
            ok = 1'b1;
          end
        end
      end
    endcase
    if (ok) begin
      // ceil(h / pixels per byte) bytes per row, h rows per glyph
      row_bytes = (height_r + PIX_PER_BYTE - 1) / PIX_PER_BYTE;
      off = header_r + longint'(idx) * row_bytes * height_r;
      r.code_valid  = 1'b1;
      r.glyph_index = idx[IDX_W-1:0];
      r.byte_offset = off[OFF_W-1:0];
      r.char_info   = {height_r, off[OFF_W-1:0]};
      r.glyph_width = height_r;
    end
    return r;
  endfunction

  // mostly in-range codes for the page, some near range limits, some noise
  function automatic logic [CODE_W-1:0] pick_char_code(logic [CP_W-1:0] cp);
    int unsigned lead;
    int unsigned trail;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel >= 80) begin
      return CODE_W'($urandom);
    end
    if (sel >= 65) begin
      return {BOUNDARY_BYTES[$urandom_range(0, 15)], BOUNDARY_BYTES[$urandom_range(0, 15)]};
    end
    case (cp)
      CP_932: begin
        lead  = $urandom_range(0, 1) ? $urandom_range('h81, 'h9F) : $urandom_range('hE0, 'hFC);
        trail = $urandom_range(0, 1) ? $urandom_range('h40, 'h7E) : $urandom_range('h80, 'hFC);
      end
      CP_936: begin
        lead  = $urandom_range('hA1, 'hFE);
        trail = $urandom_range('hA1, 'hFE);
      end
      CP_949: begin
        lead  = $urandom_range('h81, 'hFF);
        trail = $urandom_range(0, 1) ? $urandom_range('h41, 'h7E) : $urandom_range('h81, 'hFE);
      end
      default: begin
        lead  = $urandom_range('hA1, 'hFE);
        trail = $urandom_range(0, 1) ? $urandom_range('h40, 'h7E) : $urandom_range('hA1, 'hFE);
      end
    endcase
    return {lead[7:0], trail[7:0]};
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // one register write; leaves valid high, the caller lowers it
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_DATA_W-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.reg_data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_CODEPAGE: cp_sel   = data[CP_W-1:0];
      REG_HEIGHT:   height_r = data[HEIGHT_W-1:0];
      REG_HEADER:   header_r = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // full font setup; unused bits above each field carry random junk
  task automatic set_font(input logic [CP_W-1:0] cp, input logic [HEIGHT_W-1:0] h,
                          input logic [HDR_W-1:0] hdr);
    logic [REG_DATA_W-1:0] junk;
    junk = REG_DATA_W'($urandom);
    write_reg(REG_UNUSED, junk);
    junk = REG_DATA_W'($urandom);
    write_reg(REG_CODEPAGE, {junk[REG_DATA_W-1:CP_W], cp});
    junk = REG_DATA_W'($urandom);
    write_reg(REG_HEIGHT, {junk[REG_DATA_W-1:HEIGHT_W], h});
    write_reg(REG_HEADER, hdr);
    cfg_ch.valid <= 1'b0;
  endtask

  // one code transfer, with an occasional gap in front of it
  task automatic send_code(input logic [CODE_W-1:0] c, input logic lit, input glyph_addr_t lit_addr);
    pending_glyph_t p;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      code_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    code_ch.valid     <= 1'b1;
    code_ch.char_code <= c;
    @(posedge clk);
    while (!code_ch.ready) @(posedge clk);
    p.char_code = c;
    p.addr      = lit ? lit_addr : glyph_addr_of(c);
    glyph_q.push_back(p);
    @(negedge clk);
  endtask

  // empty pipeline before touching the registers
  task automatic drain_pipe();
    code_ch.valid <= 1'b0;
    while (glyph_q.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  // result side: ready drops for random bursts while idling is on
  initial begin : result_stall
    int unsigned stall;
    stall = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 17);
      end
      result_ch.ready <= (stall == 0);
    end
  end

  // every result transfer is matched against the oldest pending glyph
  always @(posedge clk) begin : result_check
    pending_glyph_t p;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (glyph_q.size() == 0) begin
        report_mismatch("result transfer with no code pending");
      end else begin
        p = glyph_q.pop_front();
        if (result_ch.code_valid !== p.addr.code_valid)
          report_mismatch($sformatf("code %04h code_valid %0b want %0b",
                                    p.char_code, result_ch.code_valid, p.addr.code_valid));
        if (result_ch.glyph_index !== p.addr.glyph_index)
          report_mismatch($sformatf("code %04h glyph_index %0d want %0d",
                                    p.char_code, result_ch.glyph_index, p.addr.glyph_index));
        if (result_ch.byte_offset !== p.addr.byte_offset)
          report_mismatch($sformatf("code %04h byte_offset %0d want %0d",
                                    p.char_code, result_ch.byte_offset, p.addr.byte_offset));
        if (result_ch.char_info !== p.addr.char_info)
          report_mismatch($sformatf("code %04h char_info %08h want %08h",
                                    p.char_code, result_ch.char_info, p.addr.char_info));
        if (result_ch.glyph_width !== p.addr.glyph_width)
          report_mismatch($sformatf("code %04h glyph_width %0d want %0d",
                                    p.char_code, result_ch.glyph_width, p.addr.glyph_width));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CP_W-1:0]     ph_cp;
    logic [HEIGHT_W-1:0] ph_height;
    logic [HDR_W-1:0]    ph_header;
    glyph_row_t          row;
    rst = 1'b1;
    code_ch.valid = 1'b0;
    code_ch.char_code = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = '0;
    cfg_ch.reg_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows; setup is rewritten only when a row asks for a new one
    for (int i = 0; i < N_DIR; i++) begin
      row = GLYPH_ROWS[i];
      if (row.cp != cp_sel || row.height != height_r || row.header != header_r) begin
        drain_pipe();
        set_font(row.cp, row.height, row.header);
      end
      send_code(row.char_code, row.lit, row.addr);
    end

    // random phases: every code page twice, height and header extremes early
    for (int p = 0; p < N_PHASES; p++) begin
      drain_pipe();
      ph_cp = CP_W'(p);
      case (p)
        0: ph_height = 6'd1;
        1: ph_height = 6'd63;
        2: ph_height = 6'd8;
        3: ph_height = 6'd9;
        default: ph_height = HEIGHT_W'($urandom_range(1, 63));
      endcase
      case (p % 3)
        0: ph_header = 16'hFFFF;
        1: ph_header = 16'h0000;
        default: ph_header = HDR_W'($urandom);
      endcase
      set_font(ph_cp, ph_height, ph_header);
      // one middle phase and the last one run flat out
      idle_on = (p != 3) && (p != N_PHASES - 1);
      for (int k = 0; k < CODES_PER_PHASE; k++) begin
        send_code(pick_char_code(cp_sel), 1'b0, NO_GLYPH);
      end
    end

    drain_pipe();
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
